[sv/sum_tree_bitfield_select_defines.svh]
// assertion macros shared by the sum tree block
`ifndef SUM_TREE_BITFIELD_SELECT_DEFINES_SVH
`define SUM_TREE_BITFIELD_SELECT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define STS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define STS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/sts_pkg.sv]
package sts_pkg;

    localparam int COUNT_W     = 10;
    localparam int LEAF_W      = 9;
    localparam int RANK_W      = 9;
    localparam int NODE_W      = 10;
    localparam int DEPTH_CFG_W = 4;

    localparam logic [DEPTH_CFG_W-1:0] DEPTH_RESET = 4'd6;

    // operation codes carried in the request
    typedef enum logic [1:0] {
        MODE_WRITE  = 2'd0,
        MODE_DECODE = 2'd1,
        MODE_FILL   = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [LEAF_W-1:0]  leaf_index;
        logic               leaf_bit;
        logic [RANK_W-1:0]  rank;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0]  node_index;
        logic [COUNT_W-1:0] total_count;
        logic               rank_ok;
    } rsp_t;

endpackage

[sv/sts_mem.sv]
module sts_mem #(
    parameter int ADDR_W = 10,
    parameter int DATA_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = (1 << ADDR_W) - 1;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/sts_ctrl.sv]
`include "sum_tree_bitfield_select_defines.svh"

module sts_ctrl #(
    parameter int ADDR_W = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_load,
    input  logic [sts_pkg::DEPTH_CFG_W-1:0]     cfg_depth,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  sts_pkg::req_t                       req,
    output logic                                res_valid,
    output sts_pkg::rsp_t                       res,
    input  logic                                res_taken,
    output logic                                mem_we,
    output logic [ADDR_W-1:0]                   mem_waddr,
    output logic [sts_pkg::COUNT_W-1:0]         mem_wdata,
    output logic                                mem_re,
    output logic [ADDR_W-1:0]                   mem_raddr,
    input  logic [sts_pkg::COUNT_W-1:0]         mem_rdata
);

    localparam int CW      = sts_pkg::COUNT_W;
    localparam int RW      = sts_pkg::RANK_W;
    localparam int DEPTH_W = $clog2(ADDR_W + 1);
    localparam int XW      = (DEPTH_W > sts_pkg::DEPTH_CFG_W) ? DEPTH_W : sts_pkg::DEPTH_CFG_W;
    localparam int CMP_W   = (ADDR_W > sts_pkg::LEAF_W) ? ADDR_W : sts_pkg::LEAF_W;
    localparam logic [ADDR_W-1:0] FULL_LAST = ADDR_W'((1 << ADDR_W) - 2);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_UP,
        S_DOWN,
        S_RESULT
    } state_t;

    state_t                state_reg, state_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [ADDR_W-1:0]     last_reg, last_next;
    logic [ADDR_W:0]       lvl_last_reg, lvl_last_next;
    logic [ADDR_W-1:0]     val_reg, val_next;
    logic                  sweep_rsp_reg, sweep_rsp_next;
    logic [ADDR_W-1:0]     cur_reg, cur_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [RW-1:0]         r_reg, r_next;
    logic [CW-1:0]         root_reg, root_next;
    sts_pkg::rsp_t         res_reg, res_next;

    logic [XW-1:0]         cfg_x;
    logic [XW-1:0]         depth_x;
    logic [DEPTH_W-1:0]    eff_depth;
    logic [ADDR_W-1:0]     leaves;
    logic [ADDR_W-1:0]     base;
    logic [ADDR_W:0]       twice;
    logic [ADDR_W-1:0]     tree_last;
    logic                  accept;

    logic [ADDR_W-1:0]     leaf_addr;
    logic [ADDR_W-1:0]     parent;
    logic [CW-1:0]         sum;
    logic [ADDR_W-1:0]     left;
    logic                  go_left;
    logic [ADDR_W-1:0]     child;
    logic [CW-1:0]         child_cnt;
    logic [CW-1:0]         r_less;

    function automatic logic [ADDR_W-1:0] sibling(input logic [ADDR_W-1:0] i);
        sibling = i[0] ? (i + ADDR_W'(1)) : (i - ADDR_W'(1));
    endfunction

    // depth in force, clamped to the supported range
    always_comb
    begin
        cfg_x = XW'(cfg_depth);
        if (cfg_x < XW'(2))
        begin
            depth_x = XW'(2);
        end
        else if (cfg_x > XW'(ADDR_W))
        begin
            depth_x = XW'(ADDR_W);
        end
        else
        begin
            depth_x = cfg_x;
        end
    end

    assign eff_depth = depth_x[DEPTH_W-1:0];
    assign leaves    = ADDR_W'(1) << (eff_depth - DEPTH_W'(1));
    assign base      = leaves - ADDR_W'(1);
    assign twice     = {leaves, 1'b0};
    assign tree_last = ADDR_W'(twice - (ADDR_W + 1)'(2));

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_valid = (state_reg == S_RESULT);
    assign res       = res_reg;

    // walk datapath
    assign leaf_addr = base + ADDR_W'(req.leaf_index);
    assign parent    = (cur_reg - ADDR_W'(1)) >> 1;
    assign sum       = cnt_reg + mem_rdata;
    assign left      = {cur_reg[ADDR_W-2:0], 1'b1};
    assign go_left   = CW'(r_reg) < mem_rdata;
    assign child     = go_left ? left : (left + ADDR_W'(1));
    assign child_cnt = go_left ? mem_rdata : (cnt_reg - mem_rdata);
    assign r_less    = CW'(r_reg) - mem_rdata;

    // next-state and memory port logic
    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        lvl_last_next  = lvl_last_reg;
        val_next       = val_reg;
        sweep_rsp_next = sweep_rsp_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        r_next         = r_reg;
        root_next      = root_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = CW'(val_reg);
        mem_re         = 1'b0;
        mem_raddr      = addr_reg;

        case (state_reg)
            S_SWEEP:
            begin
                // one entry per cycle, value halves at each level boundary
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = CW'(val_reg);
                if ({1'b0, addr_reg} == lvl_last_reg)
                begin
                    val_next      = val_reg >> 1;
                    lvl_last_next = {lvl_last_reg[ADDR_W-1:0], 1'b0} + (ADDR_W + 1)'(2);
                end
                if (addr_reg == last_reg)
                begin
                    state_next = sweep_rsp_reg ? S_RESULT : S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    res_next.node_index  = '0;
                    res_next.total_count = root_reg;
                    res_next.rank_ok     = 1'b0;
                    case (req.mode)
                        sts_pkg::MODE_WRITE:
                        begin
                            if (CMP_W'(req.leaf_index) < CMP_W'(leaves))
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = leaf_addr;
                                mem_wdata  = CW'(req.leaf_bit);
                                mem_re     = 1'b1;
                                mem_raddr  = sibling(leaf_addr);
                                cur_next   = leaf_addr;
                                cnt_next   = CW'(req.leaf_bit);
                                state_next = S_UP;
                            end
                            else
                            begin
                                state_next = S_RESULT;
                            end
                        end

                        sts_pkg::MODE_DECODE:
                        begin
                            if (CW'(req.rank) < root_reg)
                            begin
                                res_next.rank_ok = 1'b1;
                                if (root_reg > CW'(1))
                                begin
                                    mem_re     = 1'b1;
                                    mem_raddr  = ADDR_W'(1);
                                    cur_next   = '0;
                                    cnt_next   = root_reg;
                                    r_next     = req.rank;
                                    state_next = S_DOWN;
                                end
                                else
                                begin
                                    state_next = S_RESULT;
                                end
                            end
                            else
                            begin
                                state_next = S_RESULT;
                            end
                        end

                        sts_pkg::MODE_FILL:
                        begin
                            addr_next            = '0;
                            last_next            = tree_last;
                            lvl_last_next        = '0;
                            val_next             = leaves;
                            sweep_rsp_next       = 1'b1;
                            root_next            = CW'(leaves);
                            res_next.total_count = CW'(leaves);
                            state_next           = S_SWEEP;
                        end

                        sts_pkg::MODE_CLEAR:
                        begin
                            addr_next            = '0;
                            last_next            = tree_last;
                            lvl_last_next        = '0;
                            val_next             = '0;
                            sweep_rsp_next       = 1'b1;
                            root_next            = '0;
                            res_next.total_count = '0;
                            state_next           = S_SWEEP;
                        end

                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_UP:
            begin
                // parent gets its two children, sibling of parent read alongside
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = sum;
                if (parent == '0)
                begin
                    root_next            = sum;
                    res_next.total_count = sum;
                    state_next           = S_RESULT;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = sibling(parent);
                    cur_next  = parent;
                    cnt_next  = sum;
                end
            end

            S_DOWN:
            begin
                // left child count is on the read port
                cur_next = child;
                cnt_next = child_cnt;
                r_next   = go_left ? r_reg : RW'(r_less);
                if ((child_cnt > CW'(1)) && (child < base))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {child[ADDR_W-2:0], 1'b1};
                end
                else
                begin
                    res_next.node_index = sts_pkg::NODE_W'(child);
                    state_next          = S_RESULT;
                end
            end

            S_RESULT:
            begin
                if (res_taken)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write restarts a full clearing pass
        if (cfg_load)
        begin
            state_next     = S_SWEEP;
            addr_next      = '0;
            last_next      = FULL_LAST;
            lvl_last_next  = '0;
            val_next       = '0;
            sweep_rsp_next = 1'b0;
            root_next      = '0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SWEEP;
            addr_reg      <= '0;
            last_reg      <= FULL_LAST;
            lvl_last_reg  <= '0;
            val_reg       <= '0;
            sweep_rsp_reg <= 1'b0;
            root_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            last_reg      <= last_next;
            lvl_last_reg  <= lvl_last_next;
            val_reg       <= val_next;
            sweep_rsp_reg <= sweep_rsp_next;
            root_reg      <= root_next;
        end
    end

    // walk payload
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        cnt_reg <= cnt_next;
        r_reg   <= r_next;
        res_reg <= res_next;
    end

    `STS_ASSERT_IMP(a_no_rw_collide, clk, rst_n, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same entry")
    `STS_ASSERT_NXT(a_one_at_a_time, clk, rst_n, accept, !req_ready, "second request taken while one is in flight")
    `STS_ASSERT_NXT(a_cfg_blocks, clk, rst_n, cfg_load, !req_ready, "request taken during clearing pass")
    `STS_ASSERT_IMP(a_ok_needs_count, clk, rst_n, res_valid && res.rank_ok, res.total_count != '0, "rank accepted on empty tree")

endmodule

[sv/sum_tree_bitfield_select.sv]
// Sum tree over a bitfield of leaves with rank decode.
// Request channel (req_valid/req_ready/req): one operation per request,
// write one leaf bit, decode a rank, fill all leaves or clear the tree.
// Response channel (rsp_valid/rsp_ready/rsp): one response per request,
// carrying the decoded node, the root count and the rank flag.
// Configuration: cfg_wr_en/cfg_wr_data set the number of tree levels d
// (clamped to 2..MAX_DEPTH); each write starts a clearing pass.
// Counts live in one memory with a registered read; a write or a decode
// visits one tree level per cycle on that port. A leaf write stores the
// leaf and updates each parent up to the root, then offers its response;
// req_ready returns once the output register takes it. A decode walks
// down from the root, stopping above the leaves once a node's count is
// one; a leaf or rank out of range and a root count of one go straight
// to the response. Fill and clear write every node of the tree in use, one per cycle.
// After reset, and after each configuration write, the block clears all
// 2^MAX_DEPTH-1 entries with req_ready low.
// The response sits in an output register; while the receiver stalls the
// block still takes the next request and holds its response until the
// register drains.
module sum_tree_bitfield_select #(
    parameter int MAX_DEPTH = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sts_pkg::DEPTH_CFG_W-1:0]     cfg_wr_data,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  sts_pkg::req_t                       req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output sts_pkg::rsp_t                       rsp
);

    logic [sts_pkg::DEPTH_CFG_W-1:0] tree_depth_reg;
    logic                            rsp_valid_reg;
    sts_pkg::rsp_t                   rsp_reg;

    logic                            res_valid;
    sts_pkg::rsp_t                   res;
    logic                            res_taken;

    logic                            mem_we;
    logic [MAX_DEPTH-1:0]            mem_waddr;
    logic [sts_pkg::COUNT_W-1:0]     mem_wdata;
    logic                            mem_re;
    logic [MAX_DEPTH-1:0]            mem_raddr;
    logic [sts_pkg::COUNT_W-1:0]     mem_rdata;

    // depth register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_depth_reg <= sts_pkg::DEPTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            tree_depth_reg <= cfg_wr_data;
        end
    end

    // output register
    assign res_taken = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_taken)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_taken)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    sts_ctrl #(
        .ADDR_W (MAX_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_load  (cfg_wr_en),
        .cfg_depth (tree_depth_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res       (res),
        .res_taken (res_taken),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sts_mem #(
        .ADDR_W (MAX_DEPTH),
        .DATA_W (sts_pkg::COUNT_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
